>>> src/ordered_list_engine_macros.svh
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared property forms for the port checker, clocked on clk_i and
// disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");

// next-cycle implication
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");

`endif

>>> src/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// sizes, codes and shared types of the ordered list engine
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned LEN_W      = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W      = $clog2(CAPACITY);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [3:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_POS  = 4'd2,
    CMD_DEL_HEAD = 4'd3,
    CMD_DEL_TAIL = 4'd4,
    CMD_SEARCH   = 4'd5,
    CMD_READ_POS = 4'd6,
    CMD_FIND_ALL = 4'd7,
    CMD_DEL_MANY = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_BOUNDS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DROP,
    FSM_SCAN
  } fsm_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    MATCH_HOLD,
    MATCH_CAPTURE,
    MATCH_SHIFT
  } match_op_e;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    cell_op_e  data_op;
    match_op_e match_op;
    idx_t      ins_idx;
    data_t     word;
    len_t      length;
  } cell_ctrl_t;

  // low DATA_WIDTH bits of the 32-bit input word
  function automatic data_t to_data(input logic [31:0] v);
    logic [63:0] wide;
    wide = {32'd0, v};
    return wide[DATA_WIDTH-1:0];
  endfunction

  // stored entry back to the 32-bit result word
  function automatic logic [31:0] to_word(input data_t d);
    logic [63:0] wide;
    wide = 64'(d);
    return wide[31:0];
  endfunction

endpackage

`default_nettype wire

>>> src/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// one list slot: holds an entry and a match flag, shifts with its neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire olist_pkg::idx_t         cell_idx_i,
  input  wire olist_pkg::cell_ctrl_t   ctrl_i,
  input  wire olist_pkg::data_t        left_data_i,
  input  wire olist_pkg::data_t        right_data_i,
  input  wire logic                    right_flag_i,
  output olist_pkg::data_t             data_o,
  output logic                         hit_o,
  output logic                         flag_o
);

  olist_pkg::data_t data_q, data_d;
  logic             flag_q, flag_d;
  logic             occupied;

  // slot is inside the list and holds the key
  assign occupied = olist_pkg::len_t'(cell_idx_i) < ctrl_i.length;
  assign hit_o    = occupied && (data_q == ctrl_i.word);

  // entry next value
  always_comb begin
    data_d = data_q;
    case (ctrl_i.data_op)
      olist_pkg::CELL_INSERT: begin
        if (cell_idx_i == ctrl_i.ins_idx) begin
          data_d = ctrl_i.word;
        end else if (cell_idx_i > ctrl_i.ins_idx) begin
          data_d = left_data_i;
        end
      end
      olist_pkg::CELL_SHIFT: begin
        data_d = right_data_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // match flag next value
  always_comb begin
    flag_d = flag_q;
    case (ctrl_i.match_op)
      olist_pkg::MATCH_CAPTURE: flag_d = hit_o;
      olist_pkg::MATCH_SHIFT:   flag_d = right_flag_i;
      default:                  flag_d = flag_q;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign data_o = data_q;
  assign flag_o = flag_q;

endmodule

`default_nettype wire

>>> src/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// command decode, list length, multi-cycle sequencing and result register
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [3:0]            command_i,
  input  wire logic signed [31:0]    value_i,
  input  wire logic [7:0]            position_i,
  input  wire logic [7:0]            amount_i,
  input  wire olist_pkg::data_t      cell_data_i [olist_pkg::CAPACITY],
  input  wire logic [olist_pkg::CAPACITY-1:0] hit_i,
  input  wire logic [olist_pkg::CAPACITY-1:0] flag_i,
  output olist_pkg::cell_ctrl_t      cell_ctrl_o,
  output logic                       busy_o,
  output logic                       result_valid_o,
  output logic [2:0]                 status_o,
  output logic                       found_o,
  output logic signed [31:0]         read_value_o,
  output logic [6:0]                 match_position_o,
  output logic [6:0]                 list_length_o,
  output logic                       last_o
);

  olist_pkg::fsm_e    state_q, state_d;
  olist_pkg::len_t    len_q, len_d;
  olist_pkg::len_t    cnt_q, cnt_d;

  logic               valid_q, valid_d;
  olist_pkg::status_e status_q, status_d;
  logic               found_q, found_d;
  logic [31:0]        rd_q, rd_d;
  logic [6:0]         mpos_q, mpos_d;
  logic [6:0]         rlen_q;
  logic               last_q, last_d;

  logic               accept;
  logic               full;
  logic [7:0]         pos_m1;
  logic [8:0]         ins_limit;
  logic [7:0]         len8;
  logic [7:0]         drop_n;
  logic [7:0]         drop_m1;
  logic [olist_pkg::LEN_W:0] scan_pos;
  logic               scan_rest;

  assign accept    = start_i && (state_q == olist_pkg::FSM_IDLE);
  assign full      = len_q >= olist_pkg::len_t'(olist_pkg::CAPACITY);
  assign pos_m1    = position_i - 8'd1;
  assign ins_limit = 9'(len_q) + 9'd1;
  assign len8      = 8'(len_q);
  assign drop_n    = (amount_i > len8) ? len8 : amount_i;
  assign drop_m1   = drop_n - 8'd1;
  assign scan_pos  = {1'b0, cnt_q} + 1'b1;
  assign scan_rest = |flag_i[olist_pkg::CAPACITY-1:1];

  // next state, cell commands and result
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    status_d = olist_pkg::ST_OK;
    found_d  = 1'b0;
    rd_d     = '0;
    mpos_d   = '0;
    last_d   = 1'b1;

    cell_ctrl_o.data_op  = olist_pkg::CELL_HOLD;
    cell_ctrl_o.match_op = olist_pkg::MATCH_HOLD;
    cell_ctrl_o.ins_idx  = '0;
    cell_ctrl_o.word     = olist_pkg::to_data(value_i);
    cell_ctrl_o.length   = len_q;

    case (state_q)
      olist_pkg::FSM_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (olist_pkg::cmd_e'(command_i))
            olist_pkg::CMD_INS_HEAD: begin
              if (full) begin
                status_d = olist_pkg::ST_FULL;
              end else begin
                cell_ctrl_o.data_op = olist_pkg::CELL_INSERT;
                len_d               = len_q + 1'b1;
              end
            end
            olist_pkg::CMD_INS_TAIL: begin
              if (full) begin
                status_d = olist_pkg::ST_FULL;
              end else begin
                cell_ctrl_o.data_op = olist_pkg::CELL_INSERT;
                cell_ctrl_o.ins_idx = len_q[olist_pkg::IDX_W-1:0];
                len_d               = len_q + 1'b1;
              end
            end
            olist_pkg::CMD_INS_POS: begin
              if (position_i == 8'd0) begin
                status_d = olist_pkg::ST_INVALID;
              end else if ({1'b0, position_i} > ins_limit) begin
                status_d = olist_pkg::ST_BOUNDS;
              end else if (full) begin
                status_d = olist_pkg::ST_FULL;
              end else begin
                cell_ctrl_o.data_op = olist_pkg::CELL_INSERT;
                cell_ctrl_o.ins_idx = pos_m1[olist_pkg::IDX_W-1:0];
                len_d               = len_q + 1'b1;
              end
            end
            olist_pkg::CMD_DEL_HEAD: begin
              if (len_q == '0) begin
                status_d = olist_pkg::ST_EMPTY;
              end else begin
                cell_ctrl_o.data_op = olist_pkg::CELL_SHIFT;
                len_d               = len_q - 1'b1;
              end
            end
            olist_pkg::CMD_DEL_TAIL: begin
              if (len_q == '0) begin
                status_d = olist_pkg::ST_EMPTY;
              end else begin
                len_d = len_q - 1'b1;
              end
            end
            olist_pkg::CMD_SEARCH: begin
              found_d  = |hit_i;
              status_d = (|hit_i) ? olist_pkg::ST_OK : olist_pkg::ST_NOTFOUND;
            end
            olist_pkg::CMD_READ_POS: begin
              if (position_i == 8'd0) begin
                status_d = olist_pkg::ST_INVALID;
              end else if (position_i > len8) begin
                status_d = olist_pkg::ST_BOUNDS;
              end else begin
                rd_d = olist_pkg::to_word(cell_data_i[pos_m1[olist_pkg::IDX_W-1:0]]);
              end
            end
            olist_pkg::CMD_FIND_ALL: begin
              if (|hit_i) begin
                // latch match flags, then walk them out one cell a cycle
                valid_d              = 1'b0;
                cell_ctrl_o.match_op = olist_pkg::MATCH_CAPTURE;
                cnt_d                = '0;
                state_d              = olist_pkg::FSM_SCAN;
              end else begin
                status_d = olist_pkg::ST_NOTFOUND;
              end
            end
            olist_pkg::CMD_DEL_MANY: begin
              if (drop_n != 8'd0) begin
                cell_ctrl_o.data_op = olist_pkg::CELL_SHIFT;
                len_d               = len_q - 1'b1;
                if (drop_n != 8'd1) begin
                  valid_d = 1'b0;
                  cnt_d   = drop_m1[olist_pkg::LEN_W-1:0];
                  state_d = olist_pkg::FSM_DROP;
                end
              end
            end
            default: begin
              status_d = olist_pkg::ST_OK;
            end
          endcase
        end
      end
      olist_pkg::FSM_DROP: begin
        // one head removal per cycle
        cell_ctrl_o.data_op = olist_pkg::CELL_SHIFT;
        len_d               = len_q - 1'b1;
        cnt_d               = cnt_q - 1'b1;
        if (cnt_q == olist_pkg::len_t'(1)) begin
          valid_d = 1'b1;
          state_d = olist_pkg::FSM_IDLE;
        end
      end
      olist_pkg::FSM_SCAN: begin
        // head flag is the match at position cnt_q + 1
        cell_ctrl_o.match_op = olist_pkg::MATCH_SHIFT;
        cnt_d                = cnt_q + 1'b1;
        if (flag_i[0]) begin
          valid_d = 1'b1;
          found_d = 1'b1;
          mpos_d  = 7'(scan_pos);
          last_d  = !scan_rest;
        end
        if (!scan_rest) begin
          state_d = olist_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = olist_pkg::FSM_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::FSM_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    rd_q     <= rd_d;
    mpos_q   <= mpos_d;
    rlen_q   <= 7'(len_d);
    last_q   <= last_d;
  end

  assign busy_o           = state_q != olist_pkg::FSM_IDLE;
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign read_value_o     = rd_q;
  assign match_position_o = mpos_q;
  assign list_length_o    = rlen_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

>>> src/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// bounded ordered list of signed words held in a row of shifting cells
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Inserts, deletes
// of one entry, search, read and single-result commands leave busy_o low and
// may be issued back to back; their result word shows on the next cycle.
// Delete many removes one head entry per cycle through the cell row and holds
// busy_o high after the first removal when min(amount, length) exceeds one.
// Find all first latches a match flag in every cell, then shifts the flags
// out one cell a cycle up to the last match, with busy_o high while they
// shift. Results are strobed by result_valid_o for a single cycle and cannot
// be held off; the receiver must take every word as it comes.
`default_nettype none

module ordered_list_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [3:0]         command_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]         position_i,
  input  wire logic [7:0]         amount_i,
  output logic                    busy_o,
  output logic                    result_valid_o,
  output logic [2:0]              status_o,
  output logic                    found_o,
  output logic signed [31:0]      read_value_o,
  output logic [6:0]              match_position_o,
  output logic [6:0]              list_length_o,
  output logic                    last_o
);

  olist_pkg::cell_ctrl_t cell_ctrl;
  olist_pkg::data_t      cell_data [olist_pkg::CAPACITY];
  logic [olist_pkg::CAPACITY-1:0] hit;
  logic [olist_pkg::CAPACITY-1:0] flag;

  // sequencing and result register
  olist_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .command_i        (command_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .amount_i         (amount_i),
    .cell_data_i      (cell_data),
    .hit_i            (hit),
    .flag_i           (flag),
    .cell_ctrl_o      (cell_ctrl),
    .busy_o           (busy_o),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .found_o          (found_o),
    .read_value_o     (read_value_o),
    .match_position_o (match_position_o),
    .list_length_o    (list_length_o),
    .last_o           (last_o)
  );

  // row of cells, head at index zero
  for (genvar i = 0; i < olist_pkg::CAPACITY; i++) begin : g_cell
    olist_pkg::data_t left_data;
    olist_pkg::data_t right_data;
    logic             right_flag;

    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end

    if (i == olist_pkg::CAPACITY - 1) begin : g_tail
      assign right_data = '0;
      assign right_flag = 1'b0;
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
      assign right_flag = flag[i+1];
    end

    olist_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (olist_pkg::idx_t'(i)),
      .ctrl_i       (cell_ctrl),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .right_flag_i (right_flag),
      .data_o       (cell_data[i]),
      .hit_o        (hit[i]),
      .flag_o       (flag[i])
    );
  end

endmodule

`default_nettype wire

>>> src/olist_checker.sv
// ----------------------------------------------------------------------------
// olist_checker
// port-level checks of the ordered list engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_engine_macros.svh"

module olist_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               busy_o,
  input wire logic               result_valid_o,
  input wire logic [2:0]         status_o,
  input wire logic               found_o,
  input wire logic [6:0]         match_position_o,
  input wire logic [6:0]         list_length_o,
  input wire logic               last_o
);

  // a word that is not the final one comes from a running scan
  `OLE_ASSERT_IMP(a_nonlast_busy, result_valid_o && !last_o, busy_o)

  // in the next cycle the scan runs on or the final word is out
  `OLE_ASSERT_NEXT(a_nonlast_more, result_valid_o && !last_o, busy_o || result_valid_o)

  // a match always reports ok
  `OLE_ASSERT_IMP(a_found_ok, result_valid_o && found_o, status_o == olist_pkg::ST_OK)

  // a match position only comes with a match
  `OLE_ASSERT_IMP(a_mpos_found, result_valid_o && (match_position_o != 7'd0), found_o)

  // length never passes the capacity
  `OLE_ASSERT_IMP(a_len_cap, result_valid_o, list_length_o <= 7'(olist_pkg::CAPACITY))

endmodule

bind ordered_list_engine olist_checker u_olist_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// runs directed and random command words through the ordered list engine,
// keeps a shadow copy of the list and checks every result word against it
// ----------------------------------------------------------------------------

module testbench;

  localparam logic [3:0] CMD_CODE_MAX = 4'hF;

  typedef logic [31:0] word_t;

  typedef enum int unsigned {
    MODE_MIXED,
    MODE_GROW,
    MODE_SHRINK
  } burst_mode_e;

  // one expected result word
  typedef struct {
    olist_pkg::status_e status;
    logic               found;
    word_t              read_value;
    logic [6:0]         match_pos;
    logic [6:0]         length;
    logic               last;
  } list_word_t;

  // shadow list plus the queue of result words still owed by the block
  class list_scoreboard;
    olist_pkg::data_t shadow[$];
    list_word_t       pending[$];
    int unsigned      errors;
    int unsigned      commands;
    int unsigned      words_checked;
    int unsigned      full_refusals;
    int unsigned      empty_refusals;
    int unsigned      longest_find;

    task report(input string msg);
      $display("testbench: mismatch: %s", msg);
      errors++;
    endtask

    function void push_word(input olist_pkg::status_e st, input logic fnd, input word_t rd,
                            input logic [6:0] mpos, input logic lst);
      list_word_t w;
      w.status     = st;
      w.found      = fnd;
      w.read_value = rd;
      w.match_pos  = mpos;
      w.length     = 7'(shadow.size());
      w.last       = lst;
      pending.insert(pending.size(), w);
    endfunction

    // work out the words caused by one accepted command
    function void note_command(input logic [3:0] cmd, input word_t val,
                               input logic [7:0] pos, input logic [7:0] amt);
      olist_pkg::data_t   key;
      olist_pkg::status_e st;
      logic               hit;
      word_t              rd;
      int unsigned        len;
      int unsigned        n;
      int unsigned        i;
      int                 last_hit;
      int unsigned        hits;
      key  = olist_pkg::data_t'(val);
      st   = olist_pkg::ST_OK;
      hit  = 1'b0;
      rd   = '0;
      len  = shadow.size();
      commands++;
      case (cmd)
        olist_pkg::CMD_INS_HEAD: begin
          if (len >= olist_pkg::CAPACITY) st = olist_pkg::ST_FULL;
          else shadow.push_front(key);
        end
        olist_pkg::CMD_INS_TAIL: begin
          if (len >= olist_pkg::CAPACITY) st = olist_pkg::ST_FULL;
          else shadow.insert(shadow.size(), key);
        end
        olist_pkg::CMD_INS_POS: begin
          // position checks take precedence over the full check
          if (pos == 0) st = olist_pkg::ST_INVALID;
          else if (pos > len + 1) st = olist_pkg::ST_BOUNDS;
          else if (len >= olist_pkg::CAPACITY) st = olist_pkg::ST_FULL;
          else shadow.insert(pos - 1, key);
        end
        olist_pkg::CMD_DEL_HEAD: begin
          if (len == 0) st = olist_pkg::ST_EMPTY;
          else void'(shadow.pop_front());
        end
        olist_pkg::CMD_DEL_TAIL: begin
          if (len == 0) st = olist_pkg::ST_EMPTY;
          else void'(shadow.pop_back());
        end
        olist_pkg::CMD_SEARCH: begin
          for (i = 0; i < len; i++) begin
            if (shadow[i] == key) hit = 1'b1;
          end
          st = hit ? olist_pkg::ST_OK : olist_pkg::ST_NOTFOUND;
        end
        olist_pkg::CMD_READ_POS: begin
          if (pos == 0) st = olist_pkg::ST_INVALID;
          else if (pos > len) st = olist_pkg::ST_BOUNDS;
          else rd = word_t'(shadow[pos - 1]);
        end
        olist_pkg::CMD_FIND_ALL: begin
          // one word per match in position order, last flag on the final one
          last_hit = -1;
          hits     = 0;
          for (i = 0; i < len; i++) begin
            if (shadow[i] == key) last_hit = i;
          end
          for (i = 0; i < len; i++) begin
            if (shadow[i] == key) begin
              push_word(olist_pkg::ST_OK, 1'b1, '0, 7'(i + 1), (int'(i) == last_hit));
              hits++;
            end
          end
          if (hits == 0) push_word(olist_pkg::ST_NOTFOUND, 1'b0, '0, '0, 1'b1);
          if (hits > longest_find) longest_find = hits;
          return;
        end
        olist_pkg::CMD_DEL_MANY: begin
          n = (amt > len) ? len : amt;
          repeat (n) void'(shadow.pop_front());
        end
        default: ;
      endcase
      if (st == olist_pkg::ST_FULL) full_refusals++;
      if (st == olist_pkg::ST_EMPTY) empty_refusals++;
      push_word(st, hit, rd, '0, 1'b1);
    endfunction

    // compare one strobed word with the oldest expectation
    task check_word(input logic [2:0] st, input logic fnd, input word_t rd,
                    input logic [6:0] mpos, input logic [6:0] len, input logic lst);
      list_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("result word with nothing expected, status %0d", st));
        return;
      end
      w = pending.pop_front();
      words_checked++;
      if (st !== w.status)
        report($sformatf("word %0d status %0d, want %0d", words_checked, st, w.status));
      if (fnd !== w.found)
        report($sformatf("word %0d found %0b, want %0b", words_checked, fnd, w.found));
      if (rd !== w.read_value)
        report($sformatf("word %0d read value %h, want %h", words_checked, rd,
                         w.read_value));
      if (mpos !== w.match_pos)
        report($sformatf("word %0d match position %0d, want %0d", words_checked, mpos,
                         w.match_pos));
      if (len !== w.length)
        report($sformatf("word %0d length %0d, want %0d", words_checked, len, w.length));
      if (lst !== w.last)
        report($sformatf("word %0d last %0b, want %0b", words_checked, lst, w.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic [3:0] command_i;
  logic signed [31:0] value_i;
  logic [7:0] position_i;
  logic [7:0] amount_i;
  logic busy_o;
  logic result_valid_o;
  logic [2:0] status_o;
  logic found_o;
  logic signed [31:0] read_value_o;
  logic [6:0] match_position_o;
  logic [6:0] list_length_o;
  logic last_o;

  list_scoreboard sb = new();
  word_t          pool[4];

  ordered_list_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .command_i       (command_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .amount_i        (amount_i),
    .busy_o          (busy_o),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .found_o         (found_o),
    .read_value_o    (read_value_o),
    .match_position_o(match_position_o),
    .list_length_o   (list_length_o),
    .last_o          (last_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // watch both sides: results first, since they belong to earlier commands
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (result_valid_o)
        sb.check_word(status_o, found_o, read_value_o, match_position_o, list_length_o,
                      last_o);
      if (start_i && !busy_o) sb.note_command(command_i, value_i, position_i, amount_i);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // present one command word and hold it until the block takes it
  task automatic send_command(input logic [3:0] cmd, input word_t val, input logic [7:0] pos,
                              input logic [7:0] amt, input int unsigned gap);
    start_i    <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    amount_i   <= amt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every owed result word has come back
  task automatic hold_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // fill the list to capacity with mostly one key, then probe the full list
  task automatic fill_list(input word_t key, input word_t other);
    int unsigned k;
    int unsigned count;
    int unsigned len;
    logic [3:0]  cmd;
    hold_until_drained();
    len   = sb.shadow.size();
    count = olist_pkg::CAPACITY - len + 3;
    for (k = 0; k < count; k++) begin
      cmd = 4'($urandom_range(olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_INS_POS));
      send_command(cmd, ($urandom_range(7) == 0) ? other : key,
                   8'($urandom_range(1, len + 1)), 8'($urandom()), pick_gap());
      if (len < olist_pkg::CAPACITY) len++;
    end
    send_command(olist_pkg::CMD_INS_POS, key, 8'hFF, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, key, 8'h00, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, key, 8'(olist_pkg::CAPACITY + 1), '0, 0);
    send_command(olist_pkg::CMD_SEARCH, key, '0, '0, 0);
    send_command(olist_pkg::CMD_FIND_ALL, key, '0, '0, pick_gap());
    send_command(olist_pkg::CMD_READ_POS, '0, 8'(olist_pkg::CAPACITY), '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'(olist_pkg::CAPACITY + 1), '0, 0);
    send_command(olist_pkg::CMD_DEL_MANY, '0, '0, 8'($urandom()), pick_gap());
  endtask

  // a run of random commands shaped by a growth, shrink or mixed bias
  task automatic run_burst(input int unsigned count, input bit with_gaps);
    burst_mode_e mode;
    int unsigned k;
    int unsigned r;
    int unsigned len;
    logic [3:0]  cmd;
    word_t       val;
    logic [7:0]  pos;
    logic [7:0]  amt;
    mode = burst_mode_e'($urandom_range(2));
    for (k = 0; k < count; k++) begin
      len = sb.shadow.size();
      r   = $urandom_range(99);
      if (r < 4) begin
        cmd = 4'($urandom_range(olist_pkg::CMD_DEL_MANY + 1, CMD_CODE_MAX));
      end else if (mode == MODE_GROW && r < 65) begin
        cmd = 4'($urandom_range(olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_INS_POS));
      end else if (mode == MODE_SHRINK && r < 55) begin
        case ($urandom_range(4))
          0, 1:    cmd = olist_pkg::CMD_DEL_HEAD;
          2, 3:    cmd = olist_pkg::CMD_DEL_TAIL;
          default: cmd = olist_pkg::CMD_DEL_MANY;
        endcase
      end else begin
        cmd = 4'($urandom_range(olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_DEL_MANY));
      end
      val = ($urandom_range(9) < 7) ? pool[$urandom_range(3)] : word_t'($urandom());
      pos = ($urandom_range(4) != 0) ? 8'($urandom_range(len + 2)) : 8'($urandom());
      r   = $urandom_range(9);
      if (r < 7) amt = 8'($urandom_range(4));
      else if (r < 9) amt = 8'($urandom_range(len + 1));
      else amt = 8'($urandom());
      send_command(cmd, val, pos, amt, with_gaps ? pick_gap() : 0);
    end
  endtask

  // stimulus
  initial begin
    int unsigned target;
    int unsigned i;
    int unsigned r;
    int unsigned waited;
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    command_i  <= olist_pkg::CMD_INS_HEAD;
    value_i    <= '0;
    position_i <= '0;
    amount_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_command(olist_pkg::CMD_DEL_HEAD, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_DEL_TAIL, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_SEARCH, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'd1, '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'd0, '0, 0);
    send_command(olist_pkg::CMD_FIND_ALL, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_DEL_MANY, '0, '0, 8'd5, 0);
    send_command(olist_pkg::CMD_INS_POS, 32'h1234_5678, 8'd0, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, 32'h1234_5678, 8'd2, '0, 0);
    // build a short list with extreme values and a duplicate
    send_command(olist_pkg::CMD_INS_POS, 32'h8000_0000, 8'd1, '0, 0);
    send_command(olist_pkg::CMD_INS_HEAD, 32'h7FFF_FFFF, '0, '0, 0);
    send_command(olist_pkg::CMD_INS_TAIL, 32'h0000_0000, '0, '0, 0);
    send_command(olist_pkg::CMD_INS_TAIL, 32'hFFFF_FFFF, '0, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, 32'h7FFF_FFFF, 8'd5, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, 32'h7FFF_FFFF, 8'hFF, '0, 0);
    send_command(olist_pkg::CMD_INS_POS, 32'h5555_5555, 8'd2, '0, 0);
    // queries on it
    send_command(olist_pkg::CMD_SEARCH, 32'h7FFF_FFFF, '0, '0, 0);
    send_command(olist_pkg::CMD_SEARCH, 32'h0BAD_F00D, '0, '0, 0);
    send_command(olist_pkg::CMD_FIND_ALL, 32'h7FFF_FFFF, '0, '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'd1, '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'd6, '0, 0);
    send_command(olist_pkg::CMD_READ_POS, '0, 8'd7, '0, 0);
    // unused codes leave the list alone
    send_command(olist_pkg::CMD_DEL_MANY + 4'd1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0);
    send_command(CMD_CODE_MAX, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0);
    // removals, including a clamped delete many
    send_command(olist_pkg::CMD_DEL_HEAD, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_DEL_TAIL, '0, '0, '0, 0);
    send_command(olist_pkg::CMD_DEL_MANY, '0, '0, 8'd0, 0);
    send_command(olist_pkg::CMD_DEL_MANY, '0, '0, 8'hFF, 0);

    fill_list(word_t'($urandom()), word_t'($urandom()));

    // random part
    hold_until_drained();
    target = sb.commands + 320;
    while (sb.commands < target) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(11))
          0:       pool[i] = 32'h8000_0000;
          1:       pool[i] = 32'h7FFF_FFFF;
          2:       pool[i] = 32'h0000_0000;
          3:       pool[i] = 32'hFFFF_FFFF;
          default: pool[i] = word_t'($urandom());
        endcase
      end
      r = $urandom_range(9);
      if (r == 0) fill_list(pool[0], pool[1]);
      else run_burst($urandom_range(10, 40), $urandom_range(3) != 0);
      if ($urandom_range(4) == 0) hold_until_drained();
    end

    // let the last words come back
    start_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (sb.pending.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));

    $display("testbench: %0d commands, %0d result words checked, longest find-all %0d words",
             sb.commands, sb.words_checked, sb.longest_find);
    $display("testbench: %0d inserts refused on a full list, %0d deletes on an empty one",
             sb.full_refusals, sb.empty_refusals);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
